// File: design/soi_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and codes for the sparse offset index.
package soi_pkg;

    // Table size and derived widths
    localparam int TABLE_DEPTH   = 1024;
    localparam int COUNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int NUM_LEVELS    = COUNT_W;
    localparam int ENTRY_COUNT_W = 11;
    localparam int KEY_W         = 32;
    localparam int POS_W         = 32;
    localparam int OFFSET_W      = 63;
    localparam int ENTRY_W       = KEY_W + POS_W;

    // Operation codes
    localparam logic [1:0] FUNC_TRACK    = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP   = 2'd1;
    localparam logic [1:0] FUNC_TRUNCATE = 2'd2;
    localparam logic [1:0] FUNC_IGNORE   = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_STALE      = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
    localparam logic [2:0] ST_BELOW_BASE = 3'd3;
    localparam logic [2:0] ST_FULL       = 3'd4;
    localparam logic [2:0] ST_TOO_FAR    = 3'd5;

    // Configuration register indexes
    localparam logic CFG_BASE       = 1'b0;
    localparam logic CFG_STEP_BYTES = 1'b1;

    typedef struct packed {
        logic [1:0]          func;
        logic [OFFSET_W-1:0] offset;
        logic [POS_W-1:0]    position;
        logic [31:0]         rec_bytes;
    } req_t;

    typedef struct packed {
        logic [2:0]               status;
        logic                     appended;
        logic [OFFSET_W-1:0]      found_offset;
        logic [POS_W-1:0]         found_position;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } rsp_t;

    // One stored index entry
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] position;
    } entry_t;

    // Search context handed from cell to cell
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] pos;
        entry_t             acc;
        logic               rej_valid;
        entry_t             rej;
    } search_t;

endpackage

// File: design/soi_ram.sv
`timescale 1ns / 1ps
// Simple dual-port RAM with one write port and one registered read port.
module soi_ram #(
    parameter int   DEPTH  = 2,
    parameter int   WIDTH  = 8,
    localparam int  ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/soi_cell.sv
`timescale 1ns / 1ps
// One search cell: resolves one bit of the lower-bound index per cycle.
module soi_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [soi_pkg::COUNT_W-1:0] weight,
    input  logic [soi_pkg::COUNT_W-1:0] count,
    input  logic [soi_pkg::KEY_W-1:0]   rel,
    input  soi_pkg::search_t         prev,
    input  soi_pkg::entry_t          rdata,
    output soi_pkg::search_t         next
);
    import soi_pkg::*;

    logic               valid_reg;
    search_t            ctx_reg;
    logic [COUNT_W-1:0] probe;
    logic               in_range;

    // Context lines up with the RAM word read at the same edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= prev.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev.valid)
        begin
            ctx_reg <= prev;
        end
    end

    // Probe entry pos + weight - 1; step forward if its key is below rel
    assign probe    = ctx_reg.pos | weight;
    assign in_range = (probe <= count);

    always_comb
    begin
        next       = ctx_reg;
        next.valid = valid_reg;
        if (in_range)
        begin
            if (rdata.key < rel)
            begin
                next.pos = probe;
                next.acc = rdata;
            end
            else
            begin
                next.rej_valid = 1'b1;
                next.rej       = rdata;
            end
        end
    end

endmodule

// File: design/sparse_offset_index.sv
`timescale 1ns / 1ps
// Sparse offset index top level: sorted (key, position) table with a search chain.
//
// Usage:
//   req channel (req_valid/req_ready/req) takes one transaction: track, lookup
//   or truncate. rsp channel (rsp_valid/rsp_ready/rsp) returns one result per
//   request, in order. cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data)
//   writes the base offset (index 0) or step_bytes (index 1); write only when idle.
// Flow:
//   Track, ignored and rejected requests finish in the work state. Lookup and
//   truncate walk a chain of NUM_LEVELS cells (11 for 1024 entries), one cell
//   and one RAM read per cycle, then finish. A new request is taken only in
//   the idle state, after the previous one has finished.
// Reset: the table is empty, the byte accumulator is zero, the base is 0
//   and step_bytes is 32768. Table RAMs are not cleared; only entries below
//   the count are ever read.
// Stall: a finished result sits in the output register until taken. If the
//   output is still occupied when a request finishes, its result waits in a
//   hold register and no new request is accepted until it has moved on.
module sparse_offset_index (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  soi_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output soi_pkg::rsp_t rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [62:0]   cfg_data
);
    import soi_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORK,
        S_SEARCH,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;
    rsp_t                res_reg;

    logic [OFFSET_W-1:0] base_reg;
    logic [31:0]         step_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [31:0]         acc_reg;
    logic [31:0]         acc_next;
    logic [KEY_W-1:0]    last_key_reg;
    logic [KEY_W-1:0]    last_key_next;

    logic [1:0]          func_reg;
    logic [KEY_W-1:0]    rel_reg;
    logic [POS_W-1:0]    position_reg;
    logic [31:0]         size_reg;
    logic                below_reg;
    logic                far_reg;

    logic                req_fire;
    logic                slot_free;
    logic [OFFSET_W-1:0] diff;
    logic                below;
    logic                far;
    logic [32:0]         acc_sum;
    logic                reach;
    logic                stale;
    logic                full;
    logic                start;
    logic                finish;
    logic                append_we;
    rsp_t                res;
    entry_t              hit_entry;
    logic [OFFSET_W-1:0] found_sum;
    logic                rsp_load;
    rsp_t                rsp_load_data;

    search_t             chain [NUM_LEVELS+1];
    entry_t              rdata [NUM_LEVELS];
    search_t             last;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign last      = chain[NUM_LEVELS];

    // Range checks on the incoming offset
    assign below = (req.offset < base_reg);
    assign diff  = req.offset - base_reg;
    assign far   = (diff[OFFSET_W-1:KEY_W] != '0);

    // Track arithmetic
    assign acc_sum = {1'b0, acc_reg} + {1'b0, size_reg};
    assign reach   = (acc_sum >= {1'b0, step_reg});
    assign stale   = (count_reg != '0) && (last_key_reg > rel_reg);
    assign full    = (count_reg >= COUNT_W'(TABLE_DEPTH));

    // Lookup pick: exact match at the lower bound, else the entry before it
    always_comb
    begin
        if (last.rej_valid && (last.rej.key == rel_reg))
        begin
            hit_entry = last.rej;
        end
        else
        begin
            hit_entry = last.acc;
        end
    end

    assign found_sum = base_reg + {{(OFFSET_W-KEY_W){1'b0}}, hit_entry.key};

    // Chain entry point: start at position zero with nothing seen
    always_comb
    begin
        chain[0]           = '0;
        chain[0].valid     = start;
    end

    // Request execution and state updates
    always_comb
    begin
        res           = '0;
        start         = 1'b0;
        finish        = 1'b0;
        append_we     = 1'b0;
        count_next    = count_reg;
        acc_next      = acc_reg;
        last_key_next = last_key_reg;
        unique case (state_reg)
            S_WORK:
            begin
                if (func_reg == FUNC_IGNORE)
                begin
                    finish = 1'b1;
                end
                else if (below_reg)
                begin
                    finish     = 1'b1;
                    res.status = ST_BELOW_BASE;
                end
                else if (far_reg)
                begin
                    finish     = 1'b1;
                    res.status = ST_TOO_FAR;
                end
                else if (func_reg == FUNC_TRACK)
                begin
                    finish = 1'b1;
                    if (stale)
                    begin
                        res.status = ST_STALE;
                    end
                    else if (reach)
                    begin
                        if (full)
                        begin
                            res.status = ST_FULL;
                        end
                        else
                        begin
                            append_we     = 1'b1;
                            res.appended  = 1'b1;
                            count_next    = count_reg + COUNT_W'(1);
                            acc_next      = '0;
                            last_key_next = rel_reg;
                        end
                    end
                    else
                    begin
                        acc_next = acc_sum[31:0];
                    end
                end
                else
                begin
                    start = 1'b1;
                end
            end
            S_SEARCH:
            begin
                if (last.valid)
                begin
                    finish = 1'b1;
                    if (func_reg == FUNC_LOOKUP)
                    begin
                        if ((last.rej_valid && (last.rej.key == rel_reg)) || (last.pos != '0))
                        begin
                            res.found_offset   = found_sum;
                            res.found_position = hit_entry.position;
                        end
                        else
                        begin
                            res.status = ST_NOT_FOUND;
                        end
                    end
                    else
                    begin
                        count_next    = last.pos;
                        last_key_next = last.acc.key;
                    end
                end
            end
            S_IDLE, S_DONE:
            begin
            end
        endcase
        res.entry_count = ENTRY_COUNT_W'(count_next);
    end

    // Output register load: a fresh result or the held one
    assign rsp_load      = slot_free && (finish || (state_reg == S_DONE));
    assign rsp_load_data = (state_reg == S_DONE) ? res_reg : res;

    // Control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            res_reg       <= '0;
        end
        else
        begin
            if (rsp_load)
            begin
                rsp_reg       <= rsp_load_data;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_reg <= S_WORK;
                    end
                end
                S_WORK, S_SEARCH:
                begin
                    if (start)
                    begin
                        state_reg <= S_SEARCH;
                    end
                    else if (finish)
                    begin
                        if (slot_free)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            res_reg   <= res;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE:
                begin
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // Table bookkeeping and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= '0;
            step_reg     <= 32'd32768;
            count_reg    <= '0;
            acc_reg      <= '0;
            last_key_reg <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            acc_reg      <= acc_next;
            last_key_reg <= last_key_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_BASE:       base_reg <= cfg_data;
                    CFG_STEP_BYTES: step_reg <= cfg_data[31:0];
                endcase
            end
        end
    end

    // Captured request fields
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            func_reg     <= req.func;
            rel_reg      <= diff[KEY_W-1:0];
            position_reg <= req.position;
            size_reg     <= req.rec_bytes;
            below_reg    <= below;
            far_reg      <= far;
        end
    end

    // Search chain: level k resolves bit (NUM_LEVELS-1-k) of the lower bound.
    // Its RAM holds the entries whose index ends in exactly that many ones.
    genvar k;
    generate
        for (k = 0; k < NUM_LEVELS; k++)
        begin : g_level
            localparam int B  = NUM_LEVELS - 1 - k;
            localparam int RD = ((TABLE_DEPTH - (1 << B)) >> (B + 1)) + 1;
            localparam int AW = (RD > 1) ? $clog2(RD) : 1;
            localparam logic [COUNT_W-1:0] WEIGHT   = COUNT_W'(1 << B);
            localparam logic [COUNT_W-1:0] LVL_MASK = COUNT_W'((1 << (B + 1)) - 1);
            localparam logic [COUNT_W-1:0] LVL_ONES = COUNT_W'((1 << B) - 1);

            logic [AW-1:0]      raddr;
            logic [AW-1:0]      waddr;
            logic               we;
            logic [ENTRY_W-1:0] rd_word;
            entry_t             wr_entry;

            assign raddr    = AW'(chain[k].pos >> (B + 1));
            assign waddr    = AW'(count_reg >> (B + 1));
            assign we       = append_we && ((count_reg & LVL_MASK) == LVL_ONES);
            assign wr_entry = '{key: rel_reg, position: position_reg};

            soi_ram #(
                .DEPTH (RD),
                .WIDTH (ENTRY_W)
            ) u_ram (
                .clk   (clk),
                .we    (we),
                .waddr (waddr),
                .wdata (wr_entry),
                .re    (chain[k].valid),
                .raddr (raddr),
                .rdata (rd_word)
            );

            assign rdata[k] = entry_t'(rd_word);

            soi_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .weight (WEIGHT),
                .count  (count_reg),
                .rel    (rel_reg),
                .prev   (chain[k]),
                .rdata  (rdata[k]),
                .next   (chain[k+1])
            );
        end
    endgenerate

endmodule
